### hdl/lkv_pkg.sv
// ============================================================================
// lkv_pkg
// Shared types and constants for the LRU key-value cache.
// ============================================================================
package lkv_pkg;

    // Store geometry
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // Field widths
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    // Capacity register reset value
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Command codes
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // Value returned by a get that misses
    localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

    // One stored slot
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

endpackage

### hdl/lkv_ram.sv
// ============================================================================
// lkv_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module lkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### hdl/lru_key_value_cache_unit.sv
// ============================================================================
// lru_key_value_cache_unit
// Fully associative key-value cache with least-recently-used replacement.
// ============================================================================
// Usage:
//   Command channel: a command (get or put, key, value) transfers at a rising
//   edge where start is high and busy is low. busy stays high while the
//   command is worked on.
//   Result channel: o_valid pulses for one cycle with o_found and
//   o_read_value; the receiver must take it in that cycle.
//   Config: i_cfg_we writes i_cfg_wdata into the capacity register and
//   empties the store. Write only while the block is idle.
//   Timing: slots are scanned one per cycle through the single read port of
//   the slot RAM, the compare using the read data in the cycle after the
//   read. A hit ends the scan at the matching slot; a miss scans every
//   stored entry, and a command on an empty store skips the scan. The
//   result strobe is high in the first cycle with busy low, where the next
//   command may already transfer.
//   Reset: store empty, capacity 16, no result pending. Slot contents are
//   not cleared; only slots below the entry count are ever compared.
// ============================================================================
module lru_key_value_cache_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // command channel
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_command,
    input  logic signed [31:0]        i_key,
    input  logic signed [31:0]        i_value,
    // result channel
    output logic                      o_valid,
    output logic                      o_found,
    output logic signed [31:0]        o_read_value,
    // capacity register
    input  logic                      i_cfg_we,
    input  logic [4:0]                i_cfg_wdata
);

    localparam int IW = lkv_pkg::IDX_W;
    localparam int CW = lkv_pkg::CNT_W;

    // state and control registers
    lkv_pkg::t_state                 r_state, n_state;
    logic [lkv_pkg::CAP_W-1:0]       r_capacity;
    logic [CW-1:0]                   r_count, n_count;
    logic [CW-1:0]                   r_idx, n_idx;
    logic                            r_cmp_vld, n_cmp_vld;
    logic                            r_valid, n_valid;
    logic [IW-1:0]                   r_rank [lkv_pkg::MAX_ENTRIES];
    logic [IW-1:0]                   n_rank [lkv_pkg::MAX_ENTRIES];

    // payload registers
    logic                            r_cmd, n_cmd;
    logic [lkv_pkg::KEY_W-1:0]       r_key, n_key;
    logic [lkv_pkg::VAL_W-1:0]       r_value, n_value;
    logic [IW-1:0]                   r_cidx, n_cidx;
    logic [IW-1:0]                   r_slot, n_slot;
    logic [IW-1:0]                   r_victim, n_victim;
    logic                            r_hit, n_hit;
    logic [lkv_pkg::VAL_W-1:0]       r_hval, n_hval;
    logic                            r_found, n_found;
    logic [lkv_pkg::VAL_W-1:0]       r_rdval, n_rdval;

    // slot RAM
    logic                            ram_we;
    logic [IW-1:0]                   ram_waddr;
    lkv_pkg::t_entry                 ram_wdata;
    lkv_pkg::t_entry                 ram_rdata;

    // misc
    logic [CW-1:0]                   eff_cap;
    logic                            key_match;
    logic                            upd_append;
    logic [IW-1:0]                   upd_slot;
    logic [CW-1:0]                   upd_thr;
    logic                            upd_prom;

    lkv_ram #(
        .WIDTH (lkv_pkg::ENTRY_W),
        .DEPTH (lkv_pkg::MAX_ENTRIES)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    // effective capacity: zero acts as one, clamp to store size
    always_comb begin
        if (r_capacity == '0) begin
            eff_cap = CW'(1);
        end else if (int'(r_capacity) > lkv_pkg::MAX_ENTRIES) begin
            eff_cap = CW'(lkv_pkg::MAX_ENTRIES);
        end else begin
            eff_cap = CW'(r_capacity);
        end
    end

    // compare stage, on the RAM read data in the cycle after the read
    assign key_match = r_cmp_vld && (ram_rdata.key == r_key);

    // slot and recency threshold for the update step
    always_comb begin
        upd_append = 1'b0;
        upd_slot   = r_slot;
        if (!r_hit && (r_cmd == lkv_pkg::CMD_PUT)) begin
            if (r_count >= eff_cap) begin
                upd_slot = r_victim;
            end else begin
                upd_slot   = r_count[IW-1:0];
                upd_append = 1'b1;
            end
        end
        // append ages every valid slot
        upd_thr  = upd_append ? CW'(lkv_pkg::MAX_ENTRIES) : CW'(r_rank[upd_slot]);
        upd_prom = r_hit || (r_cmd == lkv_pkg::CMD_PUT);
    end

    // sequencer: next state and datapath
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_cmp_vld = r_cmp_vld;
        n_valid   = 1'b0;
        n_rank    = r_rank;
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_value   = r_value;
        n_cidx    = r_cidx;
        n_slot    = r_slot;
        n_victim  = r_victim;
        n_hit     = r_hit;
        n_hval    = r_hval;
        n_found   = r_found;
        n_rdval   = r_rdval;
        ram_we    = 1'b0;
        ram_waddr = upd_slot;
        ram_wdata = '{key: r_key, value: r_value};

        case (r_state)
            lkv_pkg::ST_IDLE: begin
                if (start) begin
                    n_cmd     = i_command;
                    n_key     = i_key;
                    n_value   = i_value;
                    n_idx     = '0;
                    n_cmp_vld = 1'b0;
                    n_hit     = 1'b0;
                    n_state   = (r_count == '0) ? lkv_pkg::ST_UPDATE : lkv_pkg::ST_SCAN;
                end
            end

            lkv_pkg::ST_SCAN: begin
                if (key_match) begin
                    n_hit   = 1'b1;
                    n_slot  = r_cidx;
                    n_hval  = ram_rdata.value;
                    n_state = lkv_pkg::ST_UPDATE;
                end else if (r_idx == r_count) begin
                    n_hit   = 1'b0;
                    n_state = lkv_pkg::ST_UPDATE;
                end else begin
                    // issue next read; track the least recent slot
                    n_cidx    = r_idx[IW-1:0];
                    n_cmp_vld = 1'b1;
                    n_idx     = r_idx + 1'b1;
                    if (r_rank[r_idx[IW-1:0]] == IW'(r_count - 1'b1)) begin
                        n_victim = r_idx[IW-1:0];
                    end
                end
            end

            lkv_pkg::ST_UPDATE: begin
                n_valid = 1'b1;
                n_found = r_hit;
                if (r_cmd == lkv_pkg::CMD_GET) begin
                    n_rdval = r_hit ? r_hval : lkv_pkg::MISS_VALUE;
                end else begin
                    n_rdval = '0;
                    ram_we  = 1'b1;
                end
                // recency update: more recent slots age by one
                if (upd_prom) begin
                    for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++) begin
                        if ((CW'(i) < r_count) && (CW'(r_rank[i]) < upd_thr)) begin
                            n_rank[i] = r_rank[i] + 1'b1;
                        end
                    end
                    n_rank[upd_slot] = '0;
                end
                if (upd_append) begin
                    n_count = r_count + 1'b1;
                end
                n_state = lkv_pkg::ST_IDLE;
            end

            default: begin
                n_state = lkv_pkg::ST_IDLE;
            end
        endcase

        // capacity write empties the store
        if (i_cfg_we) begin
            n_count = '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lkv_pkg::ST_IDLE;
            r_capacity <= lkv_pkg::CAP_RESET;
            r_count    <= '0;
            r_idx      <= '0;
            r_cmp_vld  <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_idx      <= n_idx;
            r_cmp_vld  <= n_cmp_vld;
            r_valid    <= n_valid;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rank   <= n_rank;
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_value  <= n_value;
        r_cidx   <= n_cidx;
        r_slot   <= n_slot;
        r_victim <= n_victim;
        r_hit    <= n_hit;
        r_hval   <= n_hval;
        r_found  <= n_found;
        r_rdval  <= n_rdval;
    end

    // outputs
    assign busy         = (r_state != lkv_pkg::ST_IDLE);
    assign o_valid      = r_valid;
    assign o_found      = r_found;
    assign o_read_value = r_rdval;

    // checks
    a_count_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= eff_cap)
        else $error("entry count exceeds capacity");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    a_put_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lkv_pkg::ST_UPDATE && r_cmd == lkv_pkg::CMD_PUT)
            |=> (o_valid && o_read_value == 0))
        else $error("put result not zero");

endmodule
